// ===== rtl/core/joystick_report_to_buttons_unit_defines.svh =====
// Assertion macros shared by the joystick report to button word logic.
`ifndef JOYSTICK_REPORT_TO_BUTTONS_UNIT_DEFINES_SVH
`define JOYSTICK_REPORT_TO_BUTTONS_UNIT_DEFINES_SVH

// Same-cycle implication, checked on every rising edge out of reset.
`define JRB_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising edge out of reset.
`define JRB_ASSERT_NXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/jrb_pkg.sv =====
// Types and constants of the joystick report to button word logic.
package jrb_pkg;

    // Direction found on one axis.
    typedef struct packed {
        logic neg;  // up or left
        logic pos;  // down or right
    } axis_dir_t;

    // Button function codes, one nibble per slot.
    localparam logic [3:0] FN_NONE  = 4'd0;
    localparam logic [3:0] FN_UP    = 4'd1;
    localparam logic [3:0] FN_START = 4'd9;

    // Hat switch codes that carry a direction.
    localparam logic [3:0] HAT_UP    = 4'd1;
    localparam logic [3:0] HAT_RIGHT = 4'd3;
    localparam logic [3:0] HAT_DOWN  = 4'd5;
    localparam logic [3:0] HAT_LEFT  = 4'd7;

    // Direction indices, also the bit positions in the button word.
    localparam logic [1:0] DIR_UP    = 2'd0;
    localparam logic [1:0] DIR_DOWN  = 2'd1;
    localparam logic [1:0] DIR_LEFT  = 2'd2;
    localparam logic [1:0] DIR_RIGHT = 2'd3;

    // Configuration register indices.
    localparam logic [2:0] REG_BUTTON_MAP = 3'd0;
    localparam logic [2:0] REG_VERT_MIN   = 3'd1;
    localparam logic [2:0] REG_VERT_MAX   = 3'd2;
    localparam logic [2:0] REG_HORZ_MIN   = 3'd3;
    localparam logic [2:0] REG_HORZ_MAX   = 3'd4;
    localparam logic [2:0] REG_DEADZONE   = 3'd5;

    // Register reset values.
    localparam logic [63:0] BUTTON_MAP_RST = 64'h0000_0000_9000_7658;
    localparam logic signed [16:0] AXIS_MIN_RST = 17'sd0;
    localparam logic signed [16:0] AXIS_MAX_RST = 17'sd65535;
    localparam logic [8:0] DEADZONE_RST = 9'd128;

endpackage

// ===== rtl/core/jrb_axis.sv =====
// Axis rescale and deadzone test: gives the direction of one axis value.
module jrb_axis (
    input  logic signed [16:0] value,
    input  logic signed [16:0] range_min,
    input  logic signed [16:0] range_max,
    input  logic        [8:0]  deadzone_q8,
    output jrb_pkg::axis_dir_t dir
);
    import jrb_pkg::*;

    logic signed [18:0] num;      // 2*value - min - max
    logic signed [17:0] den;      // max - min
    logic        [17:0] num_mag;
    logic        [16:0] den_mag;
    logic        [25:0] num_scaled;
    logic        [25:0] limit;
    logic               outside;
    logic               same_sign;

    always_comb begin
        num = (19'(value) <<< 1) - 19'(range_min) - 19'(range_max);
        den = 18'(range_max) - 18'(range_min);
        num_mag = num[18] ? 18'(-num) : num[17:0];
        den_mag = den[17] ? 17'(-den) : den[16:0];
        num_scaled = {num_mag, 8'd0};
        limit = 26'(deadzone_q8) * 26'(den_mag);
        outside = (num_scaled >= limit);
        same_sign = (num != 19'sd0) && (num[18] == den[17]);
        dir.pos = (den != 18'sd0) && outside && same_sign;
        dir.neg = (den != 18'sd0) && outside && !same_sign;
    end

endmodule

// ===== rtl/core/joystick_report_to_buttons_unit.sv =====
// Top level: controller report stream in, per-player button word stream out.
//
//  channel | dir | handshake          | contents
//  --------+-----+--------------------+-------------------------------------
//  s_      | in  | s_tvalid/s_tready  | one decoded report, tuser = player
//  m_      | out | m_tvalid/m_tready  | one button word, tuser = player
//  cfg_    | in  | cfg_we             | register writes, no read-back
//
//  One report a cycle sustained while m_tready stays high; m_tvalid rises once a
//  report has passed the input register, axis/map stage and direction priority stage.
//  The priority list updates combinationally, so reports never wait on each other.
//  Reset (aresetn low at a clock edge) empties the pipeline, the priority
//  list and the held directions, and reloads the register defaults.
//  A stall on m_ holds the result register; earlier stages fill, then s_tready drops.
`include "joystick_report_to_buttons_unit_defines.svh"

module joystick_report_to_buttons_unit #(
    parameter int BUTTON_SLOTS = 16   // slots read from button_bits, 1 to 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    // report channel
    input  logic        s_tvalid,
    output logic        s_tready,
    // [15:0] button_bits, [16] hat_valid, [20:17] hat_value,
    // [21] vertical_valid, [38:22] vertical_value,
    // [39] horizontal_valid, [56:40] horizontal_value, [63:57] zero
    input  logic [63:0] s_tdata,
    // [0] player_two
    input  logic        s_tuser,
    // button word channel
    output logic        m_tvalid,
    input  logic        m_tready,
    // [8:0] button_word, [15:9] zero
    output logic [15:0] m_tdata,
    // [0] result_player_two
    output logic        m_tuser,
    // configuration writes
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [63:0] cfg_wdata
);
    import jrb_pkg::*;

    typedef struct packed {
        logic               player_two;
        logic        [15:0] button_bits;
        logic               hat_valid;
        logic        [3:0]  hat_value;
        logic               vert_valid;
        logic signed [16:0] vert_value;
        logic               horz_valid;
        logic signed [16:0] horz_value;
    } report_t;

    typedef struct packed {
        logic [3:0][1:0] entry;   // entry 0 is the most recent direction
        logic [2:0]      count;
    } prio_t;

    // ---------------------------------------------------------------
    // Configuration registers
    // ---------------------------------------------------------------
    logic        [63:0] button_map_reg;
    logic signed [16:0] vert_min_reg, vert_max_reg;
    logic signed [16:0] horz_min_reg, horz_max_reg;
    logic        [8:0]  deadzone_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            button_map_reg <= BUTTON_MAP_RST;
            vert_min_reg   <= AXIS_MIN_RST;
            vert_max_reg   <= AXIS_MAX_RST;
            horz_min_reg   <= AXIS_MIN_RST;
            horz_max_reg   <= AXIS_MAX_RST;
            deadzone_reg   <= DEADZONE_RST;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_BUTTON_MAP: button_map_reg <= cfg_wdata;
                REG_VERT_MIN:   vert_min_reg   <= cfg_wdata[16:0];
                REG_VERT_MAX:   vert_max_reg   <= cfg_wdata[16:0];
                REG_HORZ_MIN:   horz_min_reg   <= cfg_wdata[16:0];
                REG_HORZ_MAX:   horz_max_reg   <= cfg_wdata[16:0];
                REG_DEADZONE:   deadzone_reg   <= cfg_wdata[8:0];
                default: ;  // drop writes past the register list
            endcase
        end
    end

    // ---------------------------------------------------------------
    // Pipeline flow control: each stage advances when the next one
    // is empty or moving.
    // ---------------------------------------------------------------
    logic    in_valid_reg, in_valid_next;
    logic    mid_valid_reg, mid_valid_next;
    logic    out_valid_reg, out_valid_next;
    logic    out_adv, mid_adv, in_load, mid_load, out_load;

    assign out_adv  = !out_valid_reg || m_tready;
    assign mid_adv  = !mid_valid_reg || out_adv;
    assign s_tready = !in_valid_reg || mid_adv;
    assign in_load  = s_tvalid && s_tready;
    assign mid_load = in_valid_reg && mid_adv;
    assign out_load = mid_valid_reg && out_adv;

    always_comb begin
        in_valid_next  = s_tready ? s_tvalid : in_valid_reg;
        mid_valid_next = mid_adv ? in_valid_reg : mid_valid_reg;
        out_valid_next = out_adv ? mid_valid_reg : out_valid_reg;
    end

    // ---------------------------------------------------------------
    // Stage 1: input register
    // ---------------------------------------------------------------
    report_t in_reg;

    always_ff @(posedge aclk) begin
        if (in_load) begin
            in_reg <= {s_tuser, s_tdata[15:0], s_tdata[16], s_tdata[20:17],
                       s_tdata[21], s_tdata[38:22], s_tdata[39], s_tdata[56:40]};
        end
    end

    // ---------------------------------------------------------------
    // Stage 2: button map, hat and axes into raw button and direction bits
    // ---------------------------------------------------------------
    axis_dir_t vert_dir, horz_dir;

    jrb_axis u_vert (
        .value       (in_reg.vert_value),
        .range_min   (vert_min_reg),
        .range_max   (vert_max_reg),
        .deadzone_q8 (deadzone_reg),
        .dir         (vert_dir)
    );

    jrb_axis u_horz (
        .value       (in_reg.horz_value),
        .range_min   (horz_min_reg),
        .range_max   (horz_max_reg),
        .deadzone_q8 (deadzone_reg),
        .dir         (horz_dir)
    );

    logic [8:0] raw_word;
    logic [3:0] slot_code;

    always_comb begin
        raw_word  = '0;
        slot_code = FN_NONE;
        for (int i = 0; i < BUTTON_SLOTS; i++) begin
            slot_code = button_map_reg[4*i +: 4];
            if (in_reg.button_bits[i] && (slot_code inside {[FN_UP:FN_START]})) begin
                raw_word[slot_code - FN_UP] = 1'b1;
            end
        end
        if (in_reg.hat_valid) begin
            case (in_reg.hat_value)
                HAT_UP:    raw_word[DIR_UP]    = 1'b1;
                HAT_RIGHT: raw_word[DIR_RIGHT] = 1'b1;
                HAT_DOWN:  raw_word[DIR_DOWN]  = 1'b1;
                HAT_LEFT:  raw_word[DIR_LEFT]  = 1'b1;
                default: ;  // other hat codes give no direction
            endcase
        end
        if (in_reg.vert_valid) begin
            if (vert_dir.pos) raw_word[DIR_DOWN] = 1'b1;
            if (vert_dir.neg) raw_word[DIR_UP]   = 1'b1;
        end
        if (in_reg.horz_valid) begin
            if (horz_dir.pos) raw_word[DIR_RIGHT] = 1'b1;
            if (horz_dir.neg) raw_word[DIR_LEFT]  = 1'b1;
        end
    end

    logic       mid_player_reg;
    logic [8:0] mid_word_reg;

    always_ff @(posedge aclk) begin
        if (mid_load) begin
            mid_player_reg <= in_reg.player_two;
            mid_word_reg   <= raw_word;
        end
    end

    // ---------------------------------------------------------------
    // Stage 3: last-pressed priority over the four directions
    // ---------------------------------------------------------------

    // Drop a direction from the list; entries are unique, so at most
    // one matches and everything behind it moves up by one.
    function automatic prio_t prio_remove(prio_t p, logic [1:0] dir);
        prio_t r;
        logic  seen;
        r    = p;
        seen = 1'b0;
        for (int k = 0; k < 3; k++) begin
            if ((3'(k) < p.count) && (p.entry[k] == dir)) seen = 1'b1;
            if (seen) r.entry[k] = p.entry[k+1];
        end
        if ((3'd3 < p.count) && (p.entry[3] == dir)) seen = 1'b1;
        r.count = p.count - 3'(seen);
        return r;
    endfunction

    // Move a direction to the front, keeping at most four entries.
    function automatic prio_t prio_push(prio_t p, logic [1:0] dir);
        prio_t r;
        r = prio_remove(p, dir);
        if (r.count > 3'd3) r.count = 3'd3;
        r.entry[3] = r.entry[2];
        r.entry[2] = r.entry[1];
        r.entry[1] = r.entry[0];
        r.entry[0] = dir;
        r.count    = r.count + 3'd1;
        return r;
    endfunction

    prio_t      prio_reg, prio_next, prio_walk;
    logic [3:0] prev_dirs_reg, prev_dirs_next;
    logic [3:0] pressed, released;
    logic [8:0] word_next;

    always_comb begin
        pressed   = mid_word_reg[3:0] & ~prev_dirs_reg;
        released  = prev_dirs_reg & ~mid_word_reg[3:0];
        prio_walk = prio_reg;
        for (int i = 0; i < 4; i++) begin
            if (pressed[i]) begin
                prio_walk = prio_push(prio_walk, 2'(i));
            end else if (released[i]) begin
                prio_walk = prio_remove(prio_walk, 2'(i));
            end
        end
        word_next = {mid_word_reg[8:4], 4'b0000};
        if (prio_walk.count != 3'd0) begin
            word_next[prio_walk.entry[0]] = 1'b1;
        end
        // hold the list unless a report passes through
        prio_next      = out_load ? prio_walk : prio_reg;
        prev_dirs_next = out_load ? mid_word_reg[3:0] : prev_dirs_reg;
    end

    logic       out_player_reg;
    logic [8:0] out_word_reg;

    always_ff @(posedge aclk) begin
        if (out_load) begin
            out_player_reg <= mid_player_reg;
            out_word_reg   <= word_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            mid_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            prio_reg      <= '0;
            prev_dirs_reg <= '0;
        end else begin
            in_valid_reg  <= in_valid_next;
            mid_valid_reg <= mid_valid_next;
            out_valid_reg <= out_valid_next;
            prio_reg      <= prio_next;
            prev_dirs_reg <= prev_dirs_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'd0, out_word_reg};
    assign m_tuser  = out_player_reg;

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    `JRB_ASSERT_IMP(a_one_direction, aclk, aresetn, m_tvalid, $onehot0(m_tdata[3:0]), "more than one direction in button word")
    `JRB_ASSERT_IMP(a_list_tracks_held, aclk, aresetn, 1'b1, 32'(prio_reg.count) == $countones(prev_dirs_reg), "priority list size differs from held directions")
    `JRB_ASSERT_NXT(a_dir_iff_list, aclk, aresetn, out_load, (m_tdata[3:0] != 4'd0) == (prio_reg.count != 3'd0), "direction bit disagrees with priority list")
    `JRB_ASSERT_NXT(a_mid_holds, aclk, aresetn, mid_valid_reg && !out_adv, mid_valid_reg && $stable(mid_word_reg), "middle stage lost a report under stall")

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for the controller report to button word encoder.
module testbench;
    import jrb_pkg::*;

    localparam int BUTTON_SLOTS = 16;
    // Watchdog bound on the whole run; leave plenty of headroom.
    localparam int CYCLE_LIMIT  = 200000;

    // One decoded controller report as it travels on s_tdata/s_tuser.
    typedef struct packed {
        logic               player_two;
        logic [15:0]        button_bits;
        logic               hat_valid;
        logic [3:0]         hat_value;
        logic               vertical_valid;
        logic signed [16:0] vertical_value;
        logic               horizontal_valid;
        logic signed [16:0] horizontal_value;
    } report_t;

    // One button word as it travels on m_tdata/m_tuser.
    typedef struct packed {
        logic       player_two;
        logic [8:0] word;
    } button_result_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [63:0] s_tdata;
    logic        s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;
    logic        m_tuser;
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [63:0] cfg_wdata;

    // Shadow copy of the configuration registers, updated on each write.
    logic [63:0]        button_map = BUTTON_MAP_RST;
    logic signed [16:0] vert_min   = AXIS_MIN_RST;
    logic signed [16:0] vert_max   = AXIS_MAX_RST;
    logic signed [16:0] horz_min   = AXIS_MIN_RST;
    logic signed [16:0] horz_max   = AXIS_MAX_RST;
    logic [8:0]         deadzone   = DEADZONE_RST;

    // Shadow copy of the direction state shared by both players.
    logic [3:0] held_dirs = '0;
    logic [1:0] prio_list [0:3] = '{default: '0};
    int         prio_count = 0;

    // Button words predicted for accepted reports, oldest first.
    button_result_t expected_words [$];
    // Reports queued up by a test, drained by send_burst.
    report_t        pending_reports [$];

    int  reports_sent   = 0;
    int  words_checked  = 0;
    int  reg_writes     = 0;
    int  mismatch_count = 0;
    // While set, that side runs without idle cycles.
    bit  sender_calm    = 1'b0;
    bit  receiver_calm  = 1'b0;

    joystick_report_to_buttons_unit #(
        .BUTTON_SLOTS(BUTTON_SLOTS)
    ) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    // Rescale one axis against its range and decide whether it leans out
    // of the deadzone. Exact integer math: |n|*256 >= deadzone*|d|.
    function automatic axis_dir_t axis_lean(input logic signed [16:0] v, lo, hi);
        longint    n, d, an, ad;
        axis_dir_t lean;
        n    = 2 * longint'(v) - longint'(lo) - longint'(hi);
        d    = longint'(hi) - longint'(lo);
        an   = (n < 0) ? -n : n;
        ad   = (d < 0) ? -d : d;
        lean = '0;
        // A zero range never gives a direction.
        if (d != 0 && an * 256 >= longint'(deadzone) * ad) begin
            if (n != 0 && ((n > 0) == (d > 0)))
                lean.pos = 1'b1;
            else
                lean.neg = 1'b1;
        end
        return lean;
    endfunction

    // Drop every copy of a direction from the last-pressed list.
    function automatic void drop_direction(input logic [1:0] dir);
        int i, j;
        j = 0;
        for (i = 0; i < prio_count; i++) begin
            if (prio_list[i] != dir) begin
                prio_list[j] = prio_list[i];
                j++;
            end
        end
        prio_count = j;
    endfunction

    // Work out the button word of one report and advance the direction state.
    function automatic button_result_t predict_button_word(input report_t r);
        button_result_t res;
        logic [8:0]     word;
        logic [3:0]     dirs, pressed, released, code;
        axis_dir_t      lean;
        int             i, j;
        word = '0;
        for (i = 0; i < BUTTON_SLOTS; i++) begin
            code = button_map[4*i +: 4];
            // Codes above start mean nothing.
            if (r.button_bits[i] && code >= FN_UP && code <= FN_START)
                word[code - FN_UP] = 1'b1;
        end
        if (r.hat_valid) begin
            case (r.hat_value)
                HAT_UP:    word[DIR_UP]    = 1'b1;
                HAT_RIGHT: word[DIR_RIGHT] = 1'b1;
                HAT_DOWN:  word[DIR_DOWN]  = 1'b1;
                HAT_LEFT:  word[DIR_LEFT]  = 1'b1;
                default: ;
            endcase
        end
        if (r.vertical_valid) begin
            lean = axis_lean(r.vertical_value, vert_min, vert_max);
            if (lean.pos)
                word[DIR_DOWN] = 1'b1;
            else if (lean.neg)
                word[DIR_UP] = 1'b1;
        end
        if (r.horizontal_valid) begin
            lean = axis_lean(r.horizontal_value, horz_min, horz_max);
            if (lean.pos)
                word[DIR_RIGHT] = 1'b1;
            else if (lean.neg)
                word[DIR_LEFT] = 1'b1;
        end
        dirs      = word[3:0];
        word[3:0] = '0;
        pressed   = dirs & ~held_dirs;
        released  = held_dirs & ~dirs;
        for (i = 0; i < 4; i++) begin
            if (pressed[i]) begin
                // Move a new press to the front; the list holds four at most.
                drop_direction(2'(i));
                if (prio_count > 3)
                    prio_count = 3;
                for (j = prio_count; j > 0; j--)
                    prio_list[j] = prio_list[j-1];
                prio_list[0] = 2'(i);
                prio_count++;
            end else if (released[i]) begin
                drop_direction(2'(i));
            end
        end
        if (prio_count != 0)
            word[prio_list[0]] = 1'b1;
        held_dirs      = dirs;
        res.player_two = r.player_two;
        res.word       = word;
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    function automatic report_t mk_report(input logic p, input logic [15:0] bits,
                                          input logic hv, input logic [3:0] hval,
                                          input logic vv, input logic signed [16:0] vval,
                                          input logic xv, input logic signed [16:0] xval);
        report_t r;
        r.player_two       = p;
        r.button_bits      = bits;
        r.hat_valid        = hv;
        r.hat_value        = hval;
        r.vertical_valid   = vv;
        r.vertical_value   = vval;
        r.horizontal_valid = xv;
        r.horizontal_value = xval;
        return r;
    endfunction

    // Append one report to the queue that send_burst drains.
    function automatic void queue_report(input report_t r);
        pending_reports = {pending_reports, r};
    endfunction

    // Pick an axis value from -32768 to 65535, leaning on both ends of that range.
    function automatic logic signed [16:0] random_axis_value();
        int v;
        case ($urandom_range(0, 5))
            0:       v = -32768;
            1:       v = 65535;
            default: v = int'($urandom_range(0, 98303)) - 32768;
        endcase
        return 17'(v);
    endfunction

    // Mostly nudge one field of the previous report so that directions
    // build up and release one at a time; now and then send pure noise.
    function automatic report_t drift_report(input report_t prev);
        report_t r;
        int      b;
        r            = prev;
        r.player_two = 1'($urandom_range(0, 1));
        case ($urandom_range(0, 9))
            0, 1: begin
                b = $urandom_range(0, 15);
                r.button_bits[b] = ~r.button_bits[b];
            end
            2: r.hat_value        = 4'($urandom_range(0, 15));
            3: r.hat_valid        = ~r.hat_valid;
            4: r.vertical_value   = random_axis_value();
            5: r.vertical_valid   = ~r.vertical_valid;
            6: r.horizontal_value = random_axis_value();
            7: r.horizontal_valid = ~r.horizontal_valid;
            default: begin
                r = mk_report(1'($urandom_range(0, 1)), 16'($urandom_range(0, 65535)),
                              1'($urandom_range(0, 1)), 4'($urandom_range(0, 15)),
                              1'($urandom_range(0, 1)), random_axis_value(),
                              1'($urandom_range(0, 1)), random_axis_value());
            end
        endcase
        return r;
    endfunction

    // Write one register; hold cfg_we for exactly one edge.
    task automatic write_reg(input logic [2:0] idx, input logic [63:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge aclk);
        cfg_we <= 1'b0;
        case (idx)
            REG_BUTTON_MAP: button_map = data;
            REG_VERT_MIN:   vert_min   = data[16:0];
            REG_VERT_MAX:   vert_max   = data[16:0];
            REG_HORZ_MIN:   horz_min   = data[16:0];
            REG_HORZ_MAX:   horz_max   = data[16:0];
            REG_DEADZONE:   deadzone   = data[8:0];
            default: ;
        endcase
        reg_writes++;
        @(posedge aclk);
    endtask

    task automatic set_axis_ranges(input logic signed [16:0] vlo, vhi, hlo, hhi);
        write_reg(REG_VERT_MIN, {47'd0, vlo});
        write_reg(REG_VERT_MAX, {47'd0, vhi});
        write_reg(REG_HORZ_MIN, {47'd0, hlo});
        write_reg(REG_HORZ_MAX, {47'd0, hhi});
    endtask

    // Send every queued report, one transaction each, with random gaps unless the sender is calm.
    task automatic send_burst();
        report_t r;
        int      gap;
        while (pending_reports.size() != 0) begin
            r = pending_reports.pop_front();
            if ($urandom_range(0, 29) == 0)
                sender_calm = ~sender_calm;
            gap = sender_calm ? 0 : $urandom_range(0, 4);
            // Lower valid only when a real gap follows, so it never
            // drops and rises within one step.
            if (gap != 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            s_tvalid <= 1'b1;
            s_tuser  <= r.player_two;
            s_tdata  <= {7'd0, r.horizontal_value, r.horizontal_valid,
                         r.vertical_value, r.vertical_valid,
                         r.hat_value, r.hat_valid, r.button_bits};
            do @(posedge aclk); while (!s_tready);
            expected_words = {expected_words, predict_button_word(r)};
            reports_sent++;
        end
        s_tvalid <= 1'b0;
    endtask

    // Hold the sender until every predicted word has come back, then let
    // the pipeline settle before any register write.
    task automatic wait_drained();
        while (expected_words.size() != 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Button slots through the default map, an identity map that also
    // reaches the unused codes, and an all-unused map.
    task automatic test_button_map();
        queue_report(mk_report(0, 16'h0000, 0, 0, 0, 0, 0, 0));
        queue_report(mk_report(1, 16'hFFFF, 0, 0, 0, 0, 0, 0));
        send_burst();
        wait_drained();
        write_reg(REG_BUTTON_MAP, 64'hFEDC_BA98_7654_3210);
        queue_report(mk_report(0, 16'h03FE, 0, 0, 0, 0, 0, 0));
        queue_report(mk_report(1, 16'hFC01, 0, 0, 0, 0, 0, 0));
        send_burst();
        wait_drained();
        write_reg(REG_BUTTON_MAP, 64'hFFFF_FFFF_FFFF_FFFF);
        queue_report(mk_report(0, 16'hFFFF, 0, 0, 0, 0, 0, 0));
        send_burst();
        wait_drained();
        write_reg(REG_BUTTON_MAP, 64'h0);
    endtask

    // The four direction codes, codes that mean nothing, and a hat with
    // its valid flag clear.
    task automatic test_hat_switch();
        queue_report(mk_report(0, 0, 1, HAT_UP,    0, 0, 0, 0));
        queue_report(mk_report(1, 0, 1, HAT_RIGHT, 0, 0, 0, 0));
        queue_report(mk_report(0, 0, 1, HAT_DOWN,  0, 0, 0, 0));
        queue_report(mk_report(1, 0, 1, HAT_LEFT,  0, 0, 0, 0));
        queue_report(mk_report(0, 0, 1, 4'd0,      0, 0, 0, 0));
        queue_report(mk_report(1, 0, 1, 4'd15,     0, 0, 0, 0));
        queue_report(mk_report(0, 0, 1, 4'd2,      0, 0, 0, 0));
        queue_report(mk_report(1, 0, 0, HAT_UP,    0, 0, 0, 0));
        send_burst();
        wait_drained();
    endtask

    // Axis extremes, a reversed range, deadzones of zero, one and above
    // one, and a zero range that must be ignored.
    task automatic test_axis_deadzone();
        set_axis_ranges(-32768, 65535, 65535, -32768);
        write_reg(REG_DEADZONE, 64'd0);
        queue_report(mk_report(0, 0, 0, 0, 1, -32768, 1, 65535));
        queue_report(mk_report(1, 0, 0, 0, 1, 16384, 1, 16384));
        send_burst();
        wait_drained();
        write_reg(REG_DEADZONE, 64'd511);
        queue_report(mk_report(0, 0, 0, 0, 1, 65535, 1, -32768));
        send_burst();
        wait_drained();
        write_reg(REG_DEADZONE, 64'd256);
        queue_report(mk_report(1, 0, 0, 0, 1, 65535, 1, -32768));
        send_burst();
        wait_drained();
        set_axis_ranges(100, 100, -5, -5);
        queue_report(mk_report(0, 0, 0, 0, 1, 65535, 1, -32768));
        send_burst();
        wait_drained();
    endtask

    // Hold several directions at once and release them out of order so
    // the last-pressed list fills, reorders and empties.
    task automatic test_priority_list();
        set_axis_ranges(AXIS_MIN_RST, AXIS_MAX_RST, AXIS_MIN_RST, AXIS_MAX_RST);
        write_reg(REG_DEADZONE, {55'd0, DEADZONE_RST});
        write_reg(REG_BUTTON_MAP, 64'h4321);
        queue_report(mk_report(0, 16'h0001, 0, 0, 0, 0, 0, 0));
        queue_report(mk_report(1, 16'h0009, 0, 0, 0, 0, 0, 0));
        queue_report(mk_report(0, 16'h000B, 0, 0, 0, 0, 0, 0));
        queue_report(mk_report(1, 16'h000F, 0, 0, 0, 0, 0, 0));
        queue_report(mk_report(0, 16'h0007, 0, 0, 0, 0, 0, 0));
        queue_report(mk_report(1, 16'h0003, 0, 0, 0, 0, 0, 0));
        queue_report(mk_report(0, 16'h0000, 0, 0, 0, 0, 0, 0));
        queue_report(mk_report(1, 16'h000F, 0, 0, 0, 0, 0, 0));
        send_burst();
        wait_drained();
    endtask

    // Load one register setting per phase: defaults, full and reversed
    // ranges with no deadzone, a zero range with a large deadzone, then
    // random settings.
    task automatic load_phase_setup(input int phase);
        logic signed [16:0] vlo, vhi, hlo, hhi;
        vlo = random_axis_value();
        vhi = ($urandom_range(0, 7) == 0) ? vlo : random_axis_value();
        hlo = random_axis_value();
        hhi = ($urandom_range(0, 7) == 0) ? hlo : random_axis_value();
        case (phase)
            0: begin
                write_reg(REG_BUTTON_MAP, BUTTON_MAP_RST);
                set_axis_ranges(AXIS_MIN_RST, AXIS_MAX_RST, AXIS_MIN_RST, AXIS_MAX_RST);
                write_reg(REG_DEADZONE, {55'd0, DEADZONE_RST});
            end
            1: begin
                write_reg(REG_BUTTON_MAP, {$urandom, $urandom});
                set_axis_ranges(-32768, 65535, 65535, -32768);
                write_reg(REG_DEADZONE, 64'd0);
            end
            2: begin
                write_reg(REG_BUTTON_MAP, {$urandom, $urandom});
                set_axis_ranges(vlo, vlo, hlo, hhi);
                write_reg(REG_DEADZONE, ($urandom_range(0, 1) != 0) ? 64'd256 : 64'd511);
            end
            default: begin
                write_reg(REG_BUTTON_MAP, {$urandom, $urandom});
                set_axis_ranges(vlo, vhi, hlo, hhi);
                write_reg(REG_DEADZONE, 64'($urandom_range(0, 300)));
            end
        endcase
    endtask

    // Random reports over five register settings, pausing halfway through
    // each phase until the pipeline has emptied.
    task automatic test_random_reports();
        report_t r;
        int      phase, half, k;
        r = mk_report(0, 0, 0, 0, 0, 0, 0, 0);
        for (phase = 0; phase < 5; phase++) begin
            load_phase_setup(phase);
            for (half = 0; half < 2; half++) begin
                for (k = 0; k < 100; k++) begin
                    r = drift_report(r);
                    queue_report(r);
                end
                send_burst();
                wait_drained();
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Result side
    // ------------------------------------------------------------------

    // Drive m_tready: draw a stall before each button word, and run
    // without stalls for stretches.
    initial begin : word_sink
        int stall;
        m_tready <= 1'b0;
        @(posedge aclk);
        forever begin
            if ($urandom_range(0, 29) == 0)
                receiver_calm = ~receiver_calm;
            stall = receiver_calm ? 0 : $urandom_range(0, 4);
            if (stall != 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
        end
    end

    // Compare each button word transaction with the oldest prediction.
    always @(posedge aclk) begin : word_checker
        button_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_words.size() == 0) begin
                mismatch_count++;
                $display("%0t: unexpected button word: expected none actual tuser %b tdata %h",
                         $time, m_tuser, m_tdata);
            end else begin
                want = expected_words.pop_front();
                words_checked++;
                if (m_tuser !== want.player_two) begin
                    mismatch_count++;
                    $display("%0t: result_player_two: expected %b actual %b",
                             $time, want.player_two, m_tuser);
                end
                if (m_tdata !== {7'd0, want.word}) begin
                    mismatch_count++;
                    $display("%0t: button_word: expected %h actual %h",
                             $time, {7'd0, want.word}, m_tdata);
                end
            end
        end
    end

    // End the run if the block stops making progress.
    initial begin : watchdog
        repeat (CYCLE_LIMIT) @(posedge aclk);
        $display("%0t: timeout with %0d button words outstanding",
                 $time, expected_words.size());
        $display("end of test: mismatches");
        $finish;
    end

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------

    initial begin
        // Drive every input to a known value and hold reset.
        aresetn   <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_index <= REG_BUTTON_MAP;
        cfg_wdata <= '0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_button_map();
        test_hat_switch();
        test_axis_deadzone();
        test_priority_list();
        test_random_reports();

        // Drain, then give the pipeline time to show any stray word.
        wait_drained();
        repeat (10) @(posedge aclk);

        $display("covered %0d reports and %0d register writes across map, hat, axis",
                 reports_sent, reg_writes);
        $display("and priority cases; %0d button words checked, %0d mismatches",
                 words_checked, mismatch_count);
        if (mismatch_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
